>>> src/utf8_stream_validator_defines.svh
// Assertion macros for the UTF-8 stream validator checker.
// Depends on nothing; included by the checker file only.
`ifndef UTF8_STREAM_VALIDATOR_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTF8V_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UTF8V_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/utf8v_pkg.sv
// Shared types and constants for the UTF-8 stream validator.
// No dependencies; imported by every RTL module of the block.
`timescale 1ns / 1ps

package utf8v_pkg;

	// Default width of the offset, line and column counters.
	localparam int POSITION_BITS_DEF = 32;
	// Width of the reported position fields.
	localparam int OUT_BITS          = 32;
	// Entries in the queue between classifier and checker.
	localparam int QUEUE_DEPTH       = 2;

	// Byte range limits.
	localparam logic [7:0] BYTE_ASCII_MAX = 8'h7F;
	localparam logic [7:0] BYTE_L2_MIN    = 8'hC2;
	localparam logic [7:0] BYTE_L2_MAX    = 8'hDF;
	localparam logic [7:0] BYTE_L3_MIN    = 8'hE0;
	localparam logic [7:0] BYTE_L3_MAX    = 8'hEF;
	localparam logic [7:0] BYTE_L4_MIN    = 8'hF0;
	localparam logic [7:0] BYTE_L4_MAX    = 8'hF4;
	localparam logic [7:0] BYTE_CONT_MASK = 8'hC0;
	localparam logic [7:0] BYTE_CONT_TAG  = 8'h80;
	localparam logic [7:0] BYTE_LIM_A0    = 8'hA0;
	localparam logic [7:0] BYTE_LEAD_ED   = 8'hED;
	localparam logic [7:0] BYTE_LIM_90    = 8'h90;
	localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;

	// Role of a byte where a new sequence would start.
	typedef enum logic [2:0] {
		KIND_ASCII,
		KIND_LEAD2,
		KIND_LEAD3,
		KIND_LEAD4,
		KIND_BAD
	} lead_kind_t;

	// Lead bytes that restrict the first continuation byte.
	typedef enum logic [2:0] {
		LC_NONE,
		LC_E0,
		LC_ED,
		LC_F0,
		LC_F4
	} lead_chk_t;

	// One classified byte beat.
	typedef struct packed {
		lead_kind_t kind;
		lead_chk_t  chk;
		logic       is_cont;
		logic       is_nl;
		logic       ge_a0;
		logic       ge_90;
		logic       last;
	} beat_t;

endpackage

>>> src/utf8v_front.sv
// Front stage: accepts raw bytes and classifies them into beats.
// Depends on utf8v_pkg.
`timescale 1ns / 1ps

module utf8v_front
	import utf8v_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       beat_valid,
	input  logic       beat_ready,
	output beat_t      beat
);

	beat_t cls;
	logic  valid_s1;
	beat_t beat_s1;

	// Classify the incoming byte with plain range compares.
	always_comb begin
		cls.kind = KIND_BAD;
		if (data_byte <= BYTE_ASCII_MAX) begin
			cls.kind = KIND_ASCII;
		end else if (data_byte >= BYTE_L2_MIN && data_byte <= BYTE_L2_MAX) begin
			cls.kind = KIND_LEAD2;
		end else if (data_byte >= BYTE_L3_MIN && data_byte <= BYTE_L3_MAX) begin
			cls.kind = KIND_LEAD3;
		end else if (data_byte >= BYTE_L4_MIN && data_byte <= BYTE_L4_MAX) begin
			cls.kind = KIND_LEAD4;
		end
		cls.chk = LC_NONE;
		if (data_byte == BYTE_L3_MIN) begin
			cls.chk = LC_E0;
		end else if (data_byte == BYTE_LEAD_ED) begin
			cls.chk = LC_ED;
		end else if (data_byte == BYTE_L4_MIN) begin
			cls.chk = LC_F0;
		end else if (data_byte == BYTE_L4_MAX) begin
			cls.chk = LC_F4;
		end
		cls.is_cont = (data_byte & BYTE_CONT_MASK) == BYTE_CONT_TAG;
		cls.is_nl   = data_byte == BYTE_NEWLINE;
		cls.ge_a0   = data_byte >= BYTE_LIM_A0;
		cls.ge_90   = data_byte >= BYTE_LIM_90;
		cls.last    = last_byte;
	end

	// Take a new byte whenever the stage is empty or draining.
	assign in_ready   = !valid_s1 || beat_ready;
	assign beat_valid = valid_s1;
	assign beat       = beat_s1;

	// Hold the stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Load the classified beat.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1 <= cls;
		end
	end

endmodule

>>> src/utf8v_queue.sv
// Small beat queue that decouples the classifier from the checker.
// Depends on utf8v_pkg.
`timescale 1ns / 1ps

module utf8v_queue
	import utf8v_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  beat_t wr_beat,
	output logic  rd_valid,
	input  logic  rd_ready,
	output beat_t rd_beat
);

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
	localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);
	localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);

	beat_t               ent_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                push;
	logic                pop;

	assign wr_ready = cnt_q != CNT_FULL;
	assign rd_valid = cnt_q != '0;
	assign rd_beat  = ent_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Advance pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_ONE;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_ONE;
			end
		end
	end

	// Store the written beat.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_beat;
		end
	end

endmodule

>>> src/utf8v_back.sv
// Back stage: sequence checker, position counters, error latch, result register.
// Depends on utf8v_pkg.
`timescale 1ns / 1ps

module utf8v_back
	import utf8v_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                beat_valid,
	output logic                beat_ready,
	input  beat_t               beat,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                stream_valid,
	output logic [OUT_BITS-1:0] error_offset,
	output logic [OUT_BITS-1:0] error_line,
	output logic [OUT_BITS-1:0] error_column
);

	localparam int                   P      = POSITION_BITS;
	localparam logic [P-1:0]         ONE    = {{(P-1){1'b0}}, 1'b1};
	localparam logic [P-1:0]         PMAX   = '1;

	// Sequence state.
	logic [1:0]   pend_q, n_pend;
	lead_chk_t    chk_q, n_chk;
	logic         expect_q, n_expect;
	logic [P-1:0] pos_q, line_q, col_q;
	logic [P-1:0] seq_start_q, n_seq_start;
	logic [P-1:0] seq_col_q, n_seq_col;
	logic         err_seen_q, n_err_seen;
	logic [P-1:0] err_off_q, n_err_off;
	logic [P-1:0] err_line_q, n_err_line;
	logic [P-1:0] err_col_q, n_err_col;

	// Error hit on this beat.
	logic         err_hit;
	logic [P-1:0] hit_off, hit_col;
	logic         first_bad;
	logic         pop;

	// Result register.
	logic                out_valid_q;
	logic                res_ok_q;
	logic [OUT_BITS-1:0] res_off_q, res_line_q, res_col_q;
	logic [OUT_BITS-1:0] cl_off, cl_line, cl_col;

	// Stall only a final beat while an earlier result still waits.
	assign beat_ready = !beat.last || !out_valid_q || out_ready;
	assign pop        = beat_valid && beat_ready;

	assign first_bad = (chk_q == LC_E0 && !beat.ge_a0) || (chk_q == LC_ED && beat.ge_a0) ||
	                   (chk_q == LC_F0 && !beat.ge_90) || (chk_q == LC_F4 && beat.ge_90);

	// Check the beat against the open sequence and latch the first error.
	always_comb begin
		n_pend      = pend_q;
		n_chk       = chk_q;
		n_expect    = expect_q;
		n_seq_start = seq_start_q;
		n_seq_col   = seq_col_q;
		err_hit     = 1'b0;
		hit_off     = seq_start_q;
		hit_col     = seq_col_q;
		if (!err_seen_q) begin
			if (pend_q == 2'd0) begin
				case (beat.kind)
					KIND_ASCII: begin
					end
					KIND_LEAD2, KIND_LEAD3, KIND_LEAD4: begin
						n_pend      = (beat.kind == KIND_LEAD2) ? 2'd1 :
						              (beat.kind == KIND_LEAD3) ? 2'd2 : 2'd3;
						n_chk       = beat.chk;
						n_expect    = 1'b1;
						n_seq_start = pos_q;
						n_seq_col   = col_q;
					end
					default: begin
						err_hit = 1'b1;
						hit_off = pos_q;
						hit_col = col_q;
					end
				endcase
			end else if (!beat.is_cont || (expect_q && first_bad)) begin
				err_hit = 1'b1;
			end else begin
				n_expect = 1'b0;
				n_pend   = pend_q - 2'd1;
			end
			// Flag a sequence cut short by the end of the stream.
			if (beat.last && !err_hit && n_pend != 2'd0) begin
				err_hit = 1'b1;
				hit_off = n_seq_start;
				hit_col = n_seq_col;
			end
		end
		n_err_seen = err_seen_q || err_hit;
		n_err_off  = err_hit ? hit_off : err_off_q;
		n_err_line = err_hit ? line_q  : err_line_q;
		n_err_col  = err_hit ? hit_col : err_col_q;
	end

	// Clamp latched positions to the reported width.
	generate
		if (P > OUT_BITS) begin : g_clamp
			assign cl_off  = (|n_err_off[P-1:OUT_BITS])  ? '1 : n_err_off[OUT_BITS-1:0];
			assign cl_line = (|n_err_line[P-1:OUT_BITS]) ? '1 : n_err_line[OUT_BITS-1:0];
			assign cl_col  = (|n_err_col[P-1:OUT_BITS])  ? '1 : n_err_col[OUT_BITS-1:0];
		end else begin : g_ext
			assign cl_off  = OUT_BITS'(n_err_off);
			assign cl_line = OUT_BITS'(n_err_line);
			assign cl_col  = OUT_BITS'(n_err_col);
		end
	endgenerate

	// Advance state per beat; clear for the next stream after the final beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 2'd0;
			chk_q       <= LC_NONE;
			expect_q    <= 1'b0;
			pos_q       <= '0;
			seq_start_q <= '0;
			line_q      <= ONE;
			col_q       <= ONE;
			seq_col_q   <= ONE;
			err_seen_q  <= 1'b0;
			err_off_q   <= '0;
			err_line_q  <= '0;
			err_col_q   <= '0;
		end else if (pop) begin
			if (beat.last) begin
				pend_q      <= 2'd0;
				chk_q       <= LC_NONE;
				expect_q    <= 1'b0;
				pos_q       <= '0;
				seq_start_q <= '0;
				line_q      <= ONE;
				col_q       <= ONE;
				seq_col_q   <= ONE;
				err_seen_q  <= 1'b0;
				err_off_q   <= '0;
				err_line_q  <= '0;
				err_col_q   <= '0;
			end else begin
				pend_q      <= n_pend;
				chk_q       <= n_chk;
				expect_q    <= n_expect;
				seq_start_q <= n_seq_start;
				seq_col_q   <= n_seq_col;
				err_seen_q  <= n_err_seen;
				err_off_q   <= n_err_off;
				err_line_q  <= n_err_line;
				err_col_q   <= n_err_col;
				pos_q       <= (pos_q == PMAX) ? pos_q : pos_q + ONE;
				if (beat.is_nl) begin
					line_q <= (line_q == PMAX) ? line_q : line_q + ONE;
					col_q  <= ONE;
				end else begin
					col_q  <= (col_q == PMAX) ? col_q : col_q + ONE;
				end
			end
		end
	end

	// Hold the result valid until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && beat.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result payload.
	always_ff @(posedge clk) begin
		if (pop && beat.last) begin
			res_ok_q   <= !n_err_seen;
			res_off_q  <= n_err_seen ? cl_off  : '0;
			res_line_q <= n_err_seen ? cl_line : '0;
			res_col_q  <= n_err_seen ? cl_col  : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign stream_valid = res_ok_q;
	assign error_offset = res_off_q;
	assign error_line   = res_line_q;
	assign error_column = res_col_q;

endmodule

>>> src/utf8_stream_validator.sv
// Top level of the strict UTF-8 stream validator.
// Depends on utf8v_pkg, utf8v_front, utf8v_queue and utf8v_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one byte per beat, data_byte
//   plus last_byte marking the final byte of a stream.
//   Output channel (out_valid/out_ready) carries one result per stream:
//   stream_valid, and for an invalid stream the offset, 1-based line and
//   1-based byte column of the first bad sequence's lead byte (all zero
//   when the stream is valid). Positions saturate.
//   Throughput: one byte per cycle, limited by the check and counter update
//   in the back stage, unless a final byte waits behind a stalled result.
//   After the final byte is accepted it passes the classifier register,
//   then the queue, and its verdict is loaded into the result register.
//   Reset clears all stream state: the block starts a fresh stream with no
//   result pending. After each final byte the state clears again by itself.
//   A stalled receiver holds the result; bytes keep flowing until a final
//   byte reaches the checker while a result still waits, and then the
//   queue and classifier fill and in_ready drops.
`timescale 1ns / 1ps

module utf8_stream_validator
	import utf8v_pkg::*;
#(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                stream_valid,
	output logic [OUT_BITS-1:0] error_offset,
	output logic [OUT_BITS-1:0] error_line,
	output logic [OUT_BITS-1:0] error_column
);

	logic  fr_valid, fr_ready;
	beat_t fr_beat;
	logic  q_valid, q_ready;
	beat_t q_beat;

	// Classify incoming bytes.
	utf8v_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.beat_valid (fr_valid),
		.beat_ready (fr_ready),
		.beat       (fr_beat)
	);

	// Decouple front and back.
	utf8v_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_beat  (fr_beat),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_beat  (q_beat)
	);

	// Check sequences and emit the result.
	utf8v_back #(
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.beat_valid   (q_valid),
		.beat_ready   (q_ready),
		.beat         (q_beat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.stream_valid (stream_valid),
		.error_offset (error_offset),
		.error_line   (error_line),
		.error_column (error_column)
	);

endmodule

>>> src/utf8v_checker.sv
// Port-level checker for the UTF-8 stream validator, bound to the top level.
// Depends on utf8_stream_validator_defines.svh and utf8v_pkg.
`timescale 1ns / 1ps
`include "utf8_stream_validator_defines.svh"

module utf8v_checker
	import utf8v_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic                stream_valid,
	input logic [OUT_BITS-1:0] error_offset,
	input logic [OUT_BITS-1:0] error_line,
	input logic [OUT_BITS-1:0] error_column
);

	// A stalled result beat holds its payload.
	`UTF8V_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(stream_valid) && $stable(error_offset) && $stable(error_line) && $stable(error_column), "result changed while stalled")

	// A valid stream reports no position.
	`UTF8V_ASSERT_NOW(a_ok_zero, clk, arst_n, out_valid && stream_valid, error_offset == '0 && error_line == '0 && error_column == '0, "valid stream with nonzero position")

	// An invalid stream reports a 1-based line and column.
	`UTF8V_ASSERT_NOW(a_err_pos, clk, arst_n, out_valid && !stream_valid, error_line != '0 && error_column != '0, "error position not 1-based")

endmodule

bind utf8_stream_validator utf8v_checker u_utf8v_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.stream_valid (stream_valid),
	.error_offset (error_offset),
	.error_line   (error_line),
	.error_column (error_column)
);

>>> verif/utf8_stream_validator_tb.sv
`timescale 1ns / 1ps
// Testbench for utf8_stream_validator: drives random and hand-built byte streams
// and checks each per-stream verdict against a built-in predictor.
// Depends on utf8v_pkg and the utf8_stream_validator RTL.

module utf8_stream_validator_tb;
	import utf8v_pkg::*;

	// Expected verdict of one stream
	typedef struct packed {
		logic                ok;
		logic [OUT_BITS-1:0] offset;
		logic [OUT_BITS-1:0] line;
		logic [OUT_BITS-1:0] column;
	} stream_verdict_t;

	// Tracks the decoder state per accepted beat and holds verdicts in flight
	class utf8_result_board;
		stream_verdict_t awaited_verdicts[$];
		int              errors;
		logic [1:0]      owed_conts;
		logic [7:0]      open_lead;
		logic            first_cont_due;
		logic [31:0]     byte_pos;
		logic [31:0]     lead_pos;
		logic [31:0]     cur_line;
		logic [31:0]     cur_col;
		logic [31:0]     lead_col;
		logic            bad_seen;
		logic [31:0]     bad_offset;
		logic [31:0]     bad_line;
		logic [31:0]     bad_column;

		function new();
			errors = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			owed_conts     = 0;
			open_lead      = 0;
			first_cont_due = 0;
			byte_pos       = 0;
			lead_pos       = 0;
			cur_line       = 1;
			cur_col        = 1;
			lead_col       = 1;
			bad_seen       = 0;
			bad_offset     = 0;
			bad_line       = 0;
			bad_column     = 0;
		endfunction

		function int pending();
			return awaited_verdicts.size();
		endfunction

		// Saturating position counter step
		function logic [31:0] bump(logic [31:0] v);
			return (v == '1) ? v : v + 32'd1;
		endfunction

		function lead_kind_t classify(logic [7:0] b);
			if (b <= BYTE_ASCII_MAX)
				return KIND_ASCII;
			if (b >= BYTE_L2_MIN && b <= BYTE_L2_MAX)
				return KIND_LEAD2;
			if (b >= BYTE_L3_MIN && b <= BYTE_L3_MAX)
				return KIND_LEAD3;
			if (b >= BYTE_L4_MIN && b <= BYTE_L4_MAX)
				return KIND_LEAD4;
			return KIND_BAD;
		endfunction

		// Keep only the first error of the stream
		function void latch_bad(logic [31:0] off, logic [31:0] ln, logic [31:0] col);
			if (bad_seen)
				return;
			bad_seen   = 1;
			bad_offset = off;
			bad_line   = ln;
			bad_column = col;
		endfunction

		function void decode_byte(logic [7:0] b);
			lead_kind_t kind;
			logic       bad_first;
			kind = classify(b);
			if (owed_conts == 0) begin
				case (kind)
					KIND_ASCII: ;
					KIND_LEAD2, KIND_LEAD3, KIND_LEAD4: begin
						owed_conts     = (kind == KIND_LEAD2) ? 2'd1 :
						                 (kind == KIND_LEAD3) ? 2'd2 : 2'd3;
						open_lead      = b;
						first_cont_due = 1;
						lead_pos       = byte_pos;
						lead_col       = cur_col;
					end
					default: latch_bad(byte_pos, cur_line, cur_col);
				endcase
				return;
			end
			// Anything but 10xxxxxx breaks the open sequence at its lead
			if ((b & BYTE_CONT_MASK) != BYTE_CONT_TAG) begin
				latch_bad(lead_pos, cur_line, lead_col);
				return;
			end
			if (first_cont_due) begin
				bad_first = (open_lead == BYTE_L3_MIN  && b <  BYTE_LIM_A0) ||
				            (open_lead == BYTE_LEAD_ED && b >= BYTE_LIM_A0) ||
				            (open_lead == BYTE_L4_MIN  && b <  BYTE_LIM_90) ||
				            (open_lead == BYTE_L4_MAX  && b >= BYTE_LIM_90);
				if (bad_first) begin
					latch_bad(lead_pos, cur_line, lead_col);
					return;
				end
				first_cont_due = 0;
			end
			owed_conts = owed_conts - 2'd1;
		endfunction

		// Advance the predictor by one accepted beat
		function void note_byte(logic [7:0] b, logic last);
			stream_verdict_t v;
			if (!bad_seen)
				decode_byte(b);
			if (!last) begin
				byte_pos = bump(byte_pos);
				if (b == BYTE_NEWLINE) begin
					cur_line = bump(cur_line);
					cur_col  = 1;
				end else begin
					cur_col = bump(cur_col);
				end
				return;
			end
			// A sequence still open at the end is truncated
			if (!bad_seen && owed_conts != 0)
				latch_bad(lead_pos, cur_line, lead_col);
			v.ok     = !bad_seen;
			v.offset = bad_seen ? bad_offset : '0;
			v.line   = bad_seen ? bad_line : '0;
			v.column = bad_seen ? bad_column : '0;
			awaited_verdicts.push_back(v);
			clear_stream();
		endfunction

		function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
			errors++;
			$error("%s: expected %0d, got %0d", field, exp_v, act_v);
		endfunction

		// Compare one result beat against the oldest expectation
		function void check_result(logic ok, logic [OUT_BITS-1:0] off,
				logic [OUT_BITS-1:0] ln, logic [OUT_BITS-1:0] col);
			stream_verdict_t v;
			if (awaited_verdicts.size() == 0) begin
				errors++;
				$error("result beat with no stream pending");
				return;
			end
			v = awaited_verdicts.pop_front();
			if (ok !== v.ok)
				report("stream_valid", v.ok, ok);
			if (off !== v.offset)
				report("error_offset", v.offset, off);
			if (ln !== v.line)
				report("error_line", v.line, ln);
			if (col !== v.column)
				report("error_column", v.column, col);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [7:0]          data_byte;
	logic                last_byte;
	logic                out_valid;
	logic                out_ready;
	logic                stream_valid;
	logic [OUT_BITS-1:0] error_offset;
	logic [OUT_BITS-1:0] error_line;
	logic [OUT_BITS-1:0] error_column;

	utf8_result_board board;
	logic [7:0]       stream_bytes[$];
	bit               quiet;
	int               bytes_sent;
	int               stream_no;

	utf8_stream_validator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.stream_valid (stream_valid),
		.error_offset (error_offset),
		.error_line   (error_line),
		.error_column (error_column)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Observe accepted beats on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_byte(data_byte, last_byte);
			if (out_valid && out_ready)
				board.check_result(stream_valid, error_offset, error_line, error_column);
		end
	end

	// Throttle the result side
	initial begin
		int hold;
		hold = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0 && !quiet) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
				hold = quiet ? 0 : pick_gap();
			end
		end
	end

	// Present one beat after an optional gap and hold it until taken
	task automatic send_beat(logic [7:0] b, logic last, int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic send_stream();
		for (int i = 0; i < stream_bytes.size(); i++)
			send_beat(stream_bytes[i], i == stream_bytes.size() - 1, quiet ? 0 : pick_gap());
		bytes_sent += stream_bytes.size();
	endtask

	// Hold the input side until every verdict is back
	task automatic drain_results();
		stop_sending();
		while (board.pending() != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] cont_byte();
		return 8'($urandom_range(8'h80, 8'hBF));
	endfunction

	// First continuation: usually legal for the lead, sometimes any continuation
	function automatic logic [7:0] first_cont(logic [7:0] lead);
		if ($urandom_range(0, 9) == 0)
			return cont_byte();
		case (lead)
			BYTE_L3_MIN:  return 8'($urandom_range(8'hA0, 8'hBF));
			BYTE_LEAD_ED: return 8'($urandom_range(8'h80, 8'h9F));
			BYTE_L4_MIN:  return 8'($urandom_range(8'h90, 8'hBF));
			BYTE_L4_MAX:  return 8'($urandom_range(8'h80, 8'h8F));
			default:      return cont_byte();
		endcase
	endfunction

	// Append one well-formed character (mostly) to the stream
	task automatic add_char();
		int         kind;
		logic [7:0] lead;
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			if ($urandom_range(0, 5) == 0)
				stream_bytes.push_back(BYTE_NEWLINE);
			else
				stream_bytes.push_back(8'($urandom_range(0, 127)));
		end else if (kind < 6) begin
			stream_bytes.push_back(8'($urandom_range(BYTE_L2_MIN, BYTE_L2_MAX)));
			stream_bytes.push_back(cont_byte());
		end else if (kind < 8) begin
			case ($urandom_range(0, 9))
				0, 1:    lead = BYTE_L3_MIN;
				2, 3:    lead = BYTE_LEAD_ED;
				default: lead = 8'($urandom_range(BYTE_L3_MIN, BYTE_L3_MAX));
			endcase
			stream_bytes.push_back(lead);
			stream_bytes.push_back(first_cont(lead));
			stream_bytes.push_back(cont_byte());
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2: lead = BYTE_L4_MIN;
				3, 4:    lead = BYTE_L4_MAX;
				default: lead = 8'($urandom_range(BYTE_L4_MIN, BYTE_L4_MAX));
			endcase
			stream_bytes.push_back(lead);
			stream_bytes.push_back(first_cont(lead));
			stream_bytes.push_back(cont_byte());
			stream_bytes.push_back(cont_byte());
		end
	endtask

	// Build a random stream: mostly well-formed text, some corrupted, some noise
	task automatic build_stream();
		int mode;
		int n;
		stream_bytes.delete();
		mode = $urandom_range(0, 99);
		if (mode < 8) begin
			n = $urandom_range(1, 12);
			repeat (n) stream_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		repeat (n) add_char();
		if (mode < 25) begin
			stream_bytes[$urandom_range(0, stream_bytes.size() - 1)] =
				8'($urandom_range(0, 255));
		end else if (mode < 35) begin
			// Leave a sequence open at the end of the stream
			stream_bytes.push_back(8'($urandom_range(BYTE_L2_MIN, BYTE_L4_MAX)));
			if ($urandom_range(0, 1) == 0)
				stream_bytes.push_back(cont_byte());
		end
	endtask

	initial begin
		$timeformat(-9, 0, " ns", 0);
		board      = new();
		quiet      = 0;
		bytes_sent = 0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		data_byte  = 8'h00;
		last_byte  = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: legal extremes, each first-continuation rule, bad leads,
		// bad continuation, truncation and line/column after a newline
		stream_bytes = {8'h00, 8'h7F, 8'hDF, 8'hBF};
		send_stream();
		stream_bytes = {8'h41, 8'h0A, 8'hE0, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_stream();
		stream_bytes = {8'h0A, 8'hED, 8'hA0};
		send_stream();
		stream_bytes = {8'h7F, 8'hFF, 8'h80};
		send_stream();
		stream_bytes = {8'hF0, 8'h8F};
		send_stream();
		stream_bytes = {8'hC2, 8'h41};
		send_stream();
		stream_bytes = {8'hE0, 8'h9F};
		send_stream();
		stream_bytes = {8'hF4, 8'h90};
		send_stream();
		stream_bytes = {8'hC1};
		send_stream();
		stream_bytes = {8'hF5};
		send_stream();
		stream_bytes = {8'hE1, 8'h80};
		send_stream();
		drain_results();

		// Random streams, with occasional quiet stretches and full drains
		stream_no = 0;
		while (bytes_sent < 1750) begin
			if (stream_no % 25 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			build_stream();
			send_stream();
			stream_no++;
			if (stream_no == 40 || $urandom_range(0, 29) == 0)
				drain_results();
		end
		stop_sending();

		// Let the last verdicts come back, then allow for pipeline latency
		while (board.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("[utf8_stream_validator] OK");
		else
			$display("[utf8_stream_validator] ERROR");
		$finish;
	end

	// Hard stop if the run hangs
	initial begin
		#5_000_000;
		$display("[utf8_stream_validator] ERROR");
		$finish;
	end

endmodule
